// ----- sv/lru_pkg.sv -----
package lru_pkg;

  // fixed port widths
  localparam int unsigned CfgW       = 5;
  localparam int unsigned PagePortW  = 16;
  localparam int unsigned FramePortW = 4;
  localparam int unsigned FaultW     = 32;

  // frames managed after reset
  localparam logic [CfgW-1:0] FramesReset = 5'd3;

  // request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

endpackage

// ----- sv/lru_page_replacement_unit.sv -----
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-----------------------------------
// in       | input     | in_valid_i / in_ready_o   | page_i
// out      | output    | out_valid_o / out_ready_i | hit_o frame_o evicted_o
//          |           |                           | evicted_page_o fault_count_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_frames_in_use_i
//
// a request walks the row of frame cells one cell per cycle, then commits once the output
// register is free; the next request is taken only after that commit, back in the idle state.
// the result sits in the output register while the next request is taken.
// a full output register holds the commit until the result is taken.
// reset clears valid bits and ranks at once; there is no clearing pass.
// cfg_ready_o is always high.
module lru_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lru_pkg::PagePortW-1:0]      page_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [lru_pkg::FramePortW-1:0]     frame_o,
  output logic                               evicted_o,
  output logic [lru_pkg::PagePortW-1:0]      evicted_page_o,
  output logic [lru_pkg::FaultW-1:0]         fault_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lru_pkg::CfgW-1:0]           cfg_frames_in_use_i
);

  import lru_pkg::*;

  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 found;
    logic [IdxW-1:0]      found_idx;
    logic [IdxW-1:0]      found_rank;
    logic                 empty;
    logic [IdxW-1:0]      empty_idx;
    logic [IdxW-1:0]      best_rank;
    logic [IdxW-1:0]      best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } tok_t;

  typedef struct packed {
    logic                 apply;
    logic [IdxW-1:0]      sel;
    logic                 was_valid;
    logic [IdxW-1:0]      old_rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  state_e state_q, state_d;

  logic [CfgW-1:0]   frames_q;
  logic [FaultW-1:0] faults_q, faults_d;

  logic [MAX_FRAMES:0] chain_v;
  tok_t                chain_t [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] active;
  tok_t                last;
  upd_t                upd;

  logic                 in_acc;
  logic                 commit;
  logic                 out_free;
  logic                 evict;
  logic [PAGE_BITS-1:0] victim;

  logic                  out_valid_q;
  logic                  hit_q;
  logic [FramePortW-1:0] frame_q;
  logic                  evicted_q;
  logic [PagePortW-1:0]  evicted_page_q;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesReset;
    end else if (cfg_valid_i) begin
      frames_q <= cfg_frames_in_use_i;
    end
  end

  // launch a fresh search request into the first cell
  always_comb begin
    chain_t[0]      = '0;
    chain_t[0].page = PAGE_BITS'(page_i);
    chain_v[0]      = in_acc;
  end

  // row of frame cells; count 0 acts as 1, large counts cover every frame
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign active[g] = (g == 0) || (32'(frames_q) > g);

    lru_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .active_i    (active[g]),
      .tok_valid_i (chain_v[g]),
      .tok_i       (chain_t[g]),
      .upd_i       (upd),
      .tok_valid_o (chain_v[g+1]),
      .tok_o       (chain_t[g+1])
    );
  end

  assign last = chain_t[MAX_FRAMES];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain_v[MAX_FRAMES]) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // decision: hit, else lowest empty frame, else oldest active frame
  always_comb begin
    upd       = '0;
    upd.apply = commit;
    upd.page  = last.page;
    evict     = 1'b0;
    victim    = '0;
    if (last.found) begin
      upd.sel       = last.found_idx;
      upd.was_valid = 1'b1;
      upd.old_rank  = last.found_rank;
    end else if (last.empty) begin
      upd.sel       = last.empty_idx;
      upd.was_valid = 1'b0;
    end else begin
      upd.sel       = last.best_idx;
      upd.was_valid = 1'b1;
      upd.old_rank  = last.best_rank;
      evict         = 1'b1;
      victim        = last.best_page;
    end
  end

  // saturating miss count
  always_comb begin
    faults_d = faults_q;
    if (!last.found && (faults_q != '1)) begin
      faults_d = faults_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q <= '0;
    end else if (commit) begin
      faults_q <= faults_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q          <= last.found;
      frame_q        <= FramePortW'(upd.sel);
      evicted_q      <= evict;
      evicted_page_q <= PagePortW'(victim);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign frame_o        = frame_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;
  assign fault_count_o  = faults_q;

endmodule

// ----- sv/lru_cell.sv -----
module lru_cell #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned CELL_IDX   = 0,
  localparam int unsigned IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int unsigned TokW  = 2 * PAGE_BITS + 5 * IdxW + 2,
  localparam int unsigned UpdW  = 2 + 2 * IdxW + PAGE_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_i,
  input  logic            tok_valid_i,
  input  logic [TokW-1:0] tok_i,
  input  logic [UpdW-1:0] upd_i,
  output logic            tok_valid_o,
  output logic [TokW-1:0] tok_o
);

  // rank width equals index width: valid ranks form a permutation of frame indices
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 found;
    logic [IdxW-1:0]      found_idx;
    logic [IdxW-1:0]      found_rank;
    logic                 empty;
    logic [IdxW-1:0]      empty_idx;
    logic [IdxW-1:0]      best_rank;
    logic [IdxW-1:0]      best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } tok_t;

  typedef struct packed {
    logic                 apply;
    logic [IdxW-1:0]      sel;
    logic                 was_valid;
    logic [IdxW-1:0]      old_rank;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  tok_t tok_in;
  tok_t tok_d, tok_q;
  upd_t upd;

  logic                 valid_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [IdxW-1:0]      rank_q;
  logic                 tok_valid_q;

  assign tok_in = tok_t'(tok_i);
  assign upd    = upd_t'(upd_i);

  // fold this frame into the passing search request
  always_comb begin
    tok_d = tok_in;
    if (active_i) begin
      if (valid_q && (page_q == tok_in.page) && !tok_in.found) begin
        tok_d.found      = 1'b1;
        tok_d.found_idx  = MyIdx;
        tok_d.found_rank = rank_q;
      end
      if (!valid_q && !tok_in.empty) begin
        tok_d.empty     = 1'b1;
        tok_d.empty_idx = MyIdx;
      end
      if (rank_q >= tok_in.best_rank) begin
        tok_d.best_rank = rank_q;
        tok_d.best_idx  = MyIdx;
        tok_d.best_page = page_q;
      end
    end
  end

  // hand-off register to the next cell, payload held once passed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= tok_d;
    end
  end

  // frame state: selected frame becomes most recent; younger valid frames age, all of them when it was empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd.apply) begin
      if (upd.sel == MyIdx) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q && (!upd.was_valid || (rank_q < upd.old_rank))) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.apply && (upd.sel == MyIdx)) begin
      page_q <= upd.page;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ----- sim/lru_checker.sv -----
module lru_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [lru_pkg::PagePortW-1:0]  page_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          hit_i,
  input  logic [lru_pkg::FramePortW-1:0] frame_i,
  input  logic                          evicted_i,
  input  logic [lru_pkg::PagePortW-1:0]  evicted_page_i,
  input  logic [lru_pkg::FaultW-1:0]     fault_count_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lru_pkg::CfgW-1:0]       cfg_frames_in_use_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lru_pkg::*;

  localparam int unsigned FrameCount = 16;

  typedef struct packed {
    logic                  hit;
    logic [FramePortW-1:0] frame;
    logic                  evicted;
    logic [PagePortW-1:0]  evicted_page;
    logic [FaultW-1:0]     fault_count;
  } page_result_t;

  // predicted frame table
  logic [PagePortW-1:0] resident_page [FrameCount];
  logic                 resident      [FrameCount];
  int unsigned          age_rank      [FrameCount];
  logic [FaultW-1:0]    fault_total;
  logic [CfgW-1:0]      frames_setting;

  page_result_t pending_results [$];
  int unsigned  mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // make a frame the most recent; younger valid frames age by one, all valid frames if it was empty
  function automatic void make_recent(input int unsigned f, input bit was_valid);
    int unsigned old_rank;
    old_rank = age_rank[f];
    for (int unsigned g = 0; g < FrameCount; g++) begin
      if (g != f && resident[g] && (!was_valid || age_rank[g] < old_rank)) begin
        age_rank[g]++;
      end
    end
    age_rank[f] = 0;
  endfunction

  // look a page up, update the table and give the outcome of the request
  function automatic page_result_t resolve_reference(input logic [PagePortW-1:0] pg);
    page_result_t r;
    int unsigned  n;
    int unsigned  sel;
    int unsigned  best;
    bit           found;
    bit           empty;
    r     = '0;
    n     = frames_setting;
    if (n < 1) n = 1;
    if (n > FrameCount) n = FrameCount;
    sel   = 0;
    found = 1'b0;
    // lowest matching active frame wins
    for (int unsigned f = 0; f < n; f++) begin
      if (!found && resident[f] && resident_page[f] == pg) begin
        sel   = f;
        found = 1'b1;
      end
    end
    if (found) begin
      make_recent(sel, 1'b1);
    end else begin
      empty = 1'b0;
      for (int unsigned f = 0; f < n; f++) begin
        if (!empty && !resident[f]) begin
          sel   = f;
          empty = 1'b1;
        end
      end
      if (empty) begin
        make_recent(sel, 1'b0);
      end else begin
        // oldest rank, highest index on a tie
        best = 0;
        for (int unsigned f = 0; f < n; f++) begin
          if (age_rank[f] >= best) begin
            best = age_rank[f];
            sel  = f;
          end
        end
        r.evicted      = 1'b1;
        r.evicted_page = resident_page[sel];
        make_recent(sel, 1'b1);
      end
      resident_page[sel] = pg;
      resident[sel]      = 1'b1;
      if (fault_total != '1) fault_total++;
    end
    r.hit         = found;
    r.frame       = sel[FramePortW-1:0];
    r.fault_count = fault_total;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // watch the channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    page_result_t due;
    if (!rst_ni) begin
      for (int unsigned f = 0; f < FrameCount; f++) begin
        resident_page[f] = '0;
        resident[f]      = 1'b0;
        age_rank[f]      = 0;
      end
      fault_total    = '0;
      frames_setting = FramesReset;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      // results first: they belong to earlier requests
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request waiting: hit %0b frame %0d evicted %0b %0h faults %0d",
                   $time, hit_i, frame_i, evicted_i, evicted_page_i, fault_count_i);
          mismatch_count++;
        end else begin
          due = pending_results.pop_front();
          compare_field("hit", 32'(due.hit), 32'(hit_i));
          compare_field("frame", 32'(due.frame), 32'(frame_i));
          compare_field("evicted", 32'(due.evicted), 32'(evicted_i));
          compare_field("evicted_page", 32'(due.evicted_page), 32'(evicted_page_i));
          compare_field("fault_count", due.fault_count, fault_count_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        frames_setting = cfg_frames_in_use_i;
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(resolve_reference(page_i));
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned PhaseCount  = 12;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [PagePortW-1:0]  page       = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  hit;
  logic [FramePortW-1:0] frame;
  logic                  evicted;
  logic [PagePortW-1:0]  evicted_page;
  logic [FaultW-1:0]     fault_count;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CfgW-1:0]       cfg_frames = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 10;
  bit          hold_request  = 1'b0;

  // frame counts for the random phases, extremes and out-of-range values among them
  logic [CfgW-1:0] frame_plan [PhaseCount] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd16, 5'd7,
                                               5'd31, 5'd8, 5'd0, 5'd15, 5'd17, 5'd5};

  always #1 clk_i = ~clk_i;

  lru_page_replacement_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .page_i              (page),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .hit_o               (hit),
    .frame_o             (frame),
    .evicted_o           (evicted),
    .evicted_page_o      (evicted_page),
    .fault_count_o       (fault_count),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_frames_in_use_i (cfg_frames)
  );

  lru_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .page_i              (page),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .hit_i               (hit),
    .frame_i             (frame),
    .evicted_i           (evicted),
    .evicted_page_i      (evicted_page),
    .fault_count_i       (fault_count),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_frames_in_use_i (cfg_frames),
    .mismatches_o        (mismatches),
    .outstanding_o       (outstanding)
  );

  // offer one page request, with an occasional idle burst in front
  task automatic offer_page(input logic [PagePortW-1:0] p);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 14);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    page     <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [CfgW-1:0] v);
    settle();
    cfg_valid  <= 1'b1;
    cfg_frames <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // mostly a small working set so that hits and evictions both happen
  function automatic logic [PagePortW-1:0] pick_page(input logic [PagePortW-1:0] base,
                                                    input int unsigned span);
    logic [PagePortW-1:0] offset;
    offset = PagePortW'($urandom_range(0, span - 1));
    case ($urandom_range(0, 9))
      0:       return PagePortW'($urandom_range(0, 65535));
      1:       return $urandom_range(0, 1) ? '0 : '1;
      default: return base + offset;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [PagePortW-1:0] base;
    logic [CfgW-1:0]      setting;
    int unsigned          active;
    int unsigned          span;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame count: page zero against cleared frames, fill, hit, evictions
    offer_page(16'h0000);
    offer_page(16'hFFFF);
    offer_page(16'h0001);
    offer_page(16'h0000);
    offer_page(16'h0002);
    offer_page(16'hFFFF);
    offer_page(16'h0001);

    // zero frames acts as one
    set_frames(5'd0);
    offer_page(16'h0005);
    offer_page(16'h0005);
    offer_page(16'h0006);

    // duplicate residents after growing the frame count
    set_frames(5'd2);
    offer_page(16'h1234);
    offer_page(16'h8001);
    set_frames(5'd1);
    offer_page(16'h8001);
    set_frames(5'd2);
    offer_page(16'h8001);
    offer_page(16'h1234);

    // frame count above the built size
    set_frames(5'd31);
    offer_page(16'h00FF);
    offer_page(16'hFF00);
    offer_page(16'h5555);
    offer_page(16'hAAAA);

    // random phases over a spread of frame counts
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      setting = (ph == PhaseCount - 1) ? CfgW'($urandom_range(0, 31)) : frame_plan[ph];
      set_frames(setting);
      active = 32'(setting);
      if (active < 1) active = 1;
      if (active > 16) active = 16;
      if (ph >= PhaseCount - 2 || ph % 4 == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(5, 40);
        recv_idle_pct = $urandom_range(2, 20);
      end
      base = PagePortW'($urandom_range(0, 65535));
      span = active + $urandom_range(0, 3);
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        if (i % 25 == 0) begin
          base = PagePortW'($urandom_range(0, 65535));
          span = active + $urandom_range(0, 3);
        end
        // long receiver hold-off while requests keep coming
        if (ph == 2 && i == 10) begin
          hold_request  = 1'b1;
          send_idle_pct = 0;
        end
        // sender pause until the block has drained
        if (ph == 5 && i == 40) settle();
        offer_page(pick_page(base, span));
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("lru_page_replacement_unit test passed");
    end else begin
      $display("lru_page_replacement_unit test failed");
    end
    $finish;
  end

  // result side: ready with random stall bursts and one long hold-off
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready   <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // timeout
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("lru_page_replacement_unit test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lru_pkg.sv
sv/lru_cell.sv
sv/lru_page_replacement_unit.sv
sim/lru_checker.sv
sim/testbench.sv
